// File: rtl/core/qcw_pkg.sv
// shared types and constants for the quadratic color wheel
`default_nettype none

package qcw_pkg;

    localparam int POS_W     = 8;
    localparam int OFS_W     = 7;
    localparam int RAD_W     = 16;
    localparam int ROOT_W    = 8;
    localparam int REM_W     = 9;
    localparam int CELL_CNT  = RAD_W / 2;

    localparam logic [POS_W-1:0] SEG1_BASE = 8'd85;
    localparam logic [POS_W-1:0] SEG2_BASE = 8'd170;
    localparam logic [10:0]      RISE_SCALE = 11'd1530;
    localparam logic [16:0]      FALL_TOP   = 17'd65025;

    localparam logic CURVE_INDEX = 1'b0;
    localparam logic CURVE_RESET = 1'b1;

    typedef enum logic [1:0] {
        SEG_RED_GREEN,
        SEG_RED_BLUE,
        SEG_GREEN_BLUE
    } segment_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } lane_t;

    typedef struct packed {
        segment_t         seg;
        logic             quad;
        logic [ROOT_W-1:0] lin_rise;
        logic [ROOT_W-1:0] lin_fall;
        lane_t            rise;
        lane_t            fall;
    } word_t;

endpackage

`default_nettype wire

// File: rtl/core/qcw_front.sv
// entry stage: segment, offset and radicands of one wheel position
`default_nettype none

module qcw_front
    import qcw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [POS_W-1:0]  in_pos,
    input  wire logic              in_quad,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output word_t                  out_word
);

    logic       valid_reg;
    word_t      word_reg;
    word_t      word_next;
    segment_t   seg;
    logic [POS_W-1:0]  ofs_full;
    logic [OFS_W-1:0]  ofs;
    logic [9:0]  ofs9;
    logic [10:0] rise_coef;
    logic [17:0] rise_prod;
    logic [13:0] ofs_sq;
    logic [16:0] ofs_sq9;
    logic [16:0] fall_val;
    logic [ROOT_W-1:0] lin_rise;

    always_comb begin
        if (in_pos < SEG1_BASE) begin
            seg      = SEG_RED_GREEN;
            ofs_full = in_pos;
        end else if (in_pos < SEG2_BASE) begin
            seg      = SEG_RED_BLUE;
            ofs_full = in_pos - SEG1_BASE;
        end else begin
            seg      = SEG_GREEN_BLUE;
            ofs_full = in_pos - SEG2_BASE;
        end
        ofs       = ofs_full[OFS_W-1:0];
        ofs9      = 10'(ofs) * 10'd9;
        rise_coef = RISE_SCALE - {1'b0, ofs9};
        rise_prod = 18'(rise_coef) * 18'(ofs);
        ofs_sq    = 14'(ofs) * 14'(ofs);
        ofs_sq9   = 17'(ofs_sq) * 17'd9;
        fall_val  = FALL_TOP - ofs_sq9;
        lin_rise  = 8'(ofs) * 8'd3;

        word_next.seg       = seg;
        word_next.quad      = in_quad;
        word_next.lin_rise  = lin_rise;
        word_next.lin_fall  = 8'd255 - lin_rise;
        word_next.rise.rad  = rise_prod[RAD_W-1:0];
        word_next.rise.rem  = '0;
        word_next.rise.root = '0;
        word_next.fall.rad  = fall_val[RAD_W-1:0];
        word_next.fall.rem  = '0;
        word_next.fall.root = '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/qcw_root_cell.sv
// one root digit cell: takes two radicand bits per lane into the root
`default_nettype none

module qcw_root_cell
    import qcw_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  word_t      in_word,
    output logic       out_valid,
    input  wire logic  out_ready,
    output word_t      out_word
);

    logic  valid_reg;
    word_t word_reg;
    word_t word_next;

    function automatic lane_t root_step(input lane_t cur);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        lane_t            nxt;
        rem_sh   = {cur.rem, cur.rad[RAD_W-1 -: 2]};
        trial    = {1'b0, cur.root[REM_W-2:0], 2'b01};
        diff     = rem_sh - trial;
        nxt.rad  = {cur.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            nxt.rem  = diff[REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = rem_sh[REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    always_comb begin
        word_next      = in_word;
        word_next.rise = root_step(in_word.rise);
        word_next.fall = root_step(in_word.fall);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/quadratic_color_wheel.sv
// top level: curve register, entry stage, root cell chain and color mapping
//
//  channel   ports                         moves
//  input     s_valid s_ready s_wheel_pos.. one wheel position per word
//  output    m_valid m_ready m_red/g/b     one color per word
//  config    apb psel..prdata              curve_quadratic at address 0
//
// one word per cycle sustained while m_ready is high; each word passes the entry
// stage and eight root cells, one root bit each for both lanes
// reset clears every stage valid bit and sets the curve to quadratic
// a stalled output holds its word; upstream stages keep filling bubbles
`default_nettype none

module quadratic_color_wheel
    import qcw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [POS_W-1:0]  s_wheel_position,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ROOT_W-1:0]      m_red,
    output logic [ROOT_W-1:0]      m_green,
    output logic [ROOT_W-1:0]      m_blue,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic  curve_reg;
    logic  cfg_write;
    logic  up_sel_quad;
    logic [ROOT_W-1:0] up;
    logic [ROOT_W-1:0] down;

    logic  stage_valid [CELL_CNT+1];
    logic  stage_ready [CELL_CNT+1];
    word_t stage_word  [CELL_CNT+1];
    word_t last_word;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CURVE_INDEX);
    assign prdata    = (paddr[2] == CURVE_INDEX) ? {31'b0, curve_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_reg <= CURVE_RESET;
        end else if (cfg_write) begin
            curve_reg <= pwdata[0];
        end
    end

    qcw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pos    (s_wheel_position),
        .in_quad   (curve_reg),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_word  (stage_word[0])
    );

    for (genvar i = 0; i < CELL_CNT; i++) begin : g_cell
        qcw_root_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    assign last_word             = stage_word[CELL_CNT];
    assign m_valid               = stage_valid[CELL_CNT];
    assign stage_ready[CELL_CNT] = m_ready;

    assign up_sel_quad = last_word.quad;
    assign up   = up_sel_quad ? last_word.rise.root : last_word.lin_rise;
    assign down = up_sel_quad ? last_word.fall.root : last_word.lin_fall;

    always_comb begin
        m_red   = '0;
        m_green = '0;
        m_blue  = '0;
        unique case (last_word.seg)
            SEG_RED_GREEN: begin
                m_red   = up;
                m_green = down;
            end
            SEG_RED_BLUE: begin
                m_red   = down;
                m_blue  = up;
            end
            SEG_GREEN_BLUE: begin
                m_green = up;
                m_blue  = down;
            end
            default: begin
                m_red   = '0;
            end
        endcase
    end

    // one component is always zero
    a_one_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red == '0 || m_green == '0 || m_blue == '0))
        else $error("all three color components nonzero");

    // input only backs up when the chain is full to the output
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output not stalled");

    // curve register takes the written bit
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> (curve_reg == $past(pwdata[0])))
        else $error("curve register missed a write");

    // linear ramp pair always sums to full scale
    a_linear_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !last_word.quad) |-> ((9'(up) + 9'(down)) == 9'd255))
        else $error("linear ramp pair out of step");

endmodule

`default_nettype wire
